// ----- rtl/core/lobm_pkg.sv -----
`default_nettype none
package lobm_pkg;

  localparam int BOOK_ENTRIES_DEF = 32;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_TRADE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // One order slot of the book as it is kept in the entry memory.
  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [30:0] remaining;
    logic [31:0] order_ident;
    logic [31:0] instrument;
    logic [31:0] market;
    logic [23:0] currency;
    logic [31:0] arrival;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEST,
    S_CHECK,
    S_BRD,
    S_BCHK,
    S_ASCAN,
    S_TRADE,
    S_WB2,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/limit_order_book_matcher.sv -----
`default_nettype none
// Add item: its one result is registered at the accepting edge and offered the next cycle.
// Match item: each round scans the entry memory for best prices, checks for a cross,
// then scans bids and, for each bid at the best price, all asks, then writes back the
// bid with the trade result in S_TRADE and the ask in S_WB2.
// One item is worked on at a time; the next is taken once the block is idle and the output
// register is free. Synchronous active-low reset clears all valid bits and the arrival
// stamp, and sets the trade counter to one.
module limit_order_book_matcher #(
  parameter int BOOK_ENTRIES = lobm_pkg::BOOK_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic        in_side,
  input  wire logic [31:0] in_limit_price,
  input  wire logic [30:0] in_order_quantity,
  input  wire logic [31:0] in_order_ident,
  input  wire logic [31:0] in_instrument_ident,
  input  wire logic [31:0] in_market_code,
  input  wire logic [23:0] in_currency_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_trade_number,
  output logic [31:0]      out_buyer_ident,
  output logic [31:0]      out_seller_ident,
  output logic [31:0]      out_trade_price,
  output logic [30:0]      out_trade_quantity,
  output logic [31:0]      out_trade_market,
  output logic [23:0]      out_trade_currency,
  output logic [5:0]       out_trades_done,
  output logic             out_last
);

  localparam int IW = $clog2(BOOK_ENTRIES);
  localparam int CW = $clog2(BOOK_ENTRIES + 1);

  // The whole order book lives in this memory; only the valid bits are flops.
  lobm_pkg::entry_t mem [BOOK_ENTRIES];
  lobm_pkg::entry_t rd_a_q, rd_b_q;
  logic [IW-1:0]    addr_a, addr_b, mem_waddr;
  lobm_pkg::entry_t mem_wdata;
  logic             mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  lobm_pkg::state_t state_r, state_nxt;
  logic [BOOK_ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0] arr_cnt_r, arr_cnt_nxt, trd_cnt_r, trd_cnt_nxt;
  logic [CW-1:0] sc_r, sc_nxt, ntr_r, ntr_nxt;
  logic [IW-1:0] b_r, b_nxt, pb_idx_r, pb_idx_nxt, pa_idx_r, pa_idx_nxt;
  logic have_bid_r, have_bid_nxt, have_ask_r, have_ask_nxt, found_r, found_nxt;
  logic [31:0] best_bid_r, best_bid_nxt, best_ask_r, best_ask_nxt;
  lobm_pkg::entry_t pb_r, pb_nxt, pa_r, pa_nxt, bd_r, bd_nxt;
  logic [31:0] pb_age_r, pb_age_nxt, pa_age_r, pa_age_nxt, bd_age_r, bd_age_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [31:0] o_tnum_r, o_tnum_nxt, o_buy_r, o_buy_nxt, o_sell_r, o_sell_nxt;
  logic [31:0] o_price_r, o_price_nxt, o_mkt_r, o_mkt_nxt;
  logic [30:0] o_qty_r, o_qty_nxt;
  logic [23:0] o_cur_r, o_cur_nxt;
  logic [5:0]  o_done_r, o_done_nxt;
  logic        o_last_r, o_last_nxt;

  logic          out_ok, in_acc, full;
  logic [IW-1:0] free_idx;
  logic [CW-1:0] sc_m1;
  logic [IW-1:0] e_idx;
  logic [31:0]   age_a;
  logic [30:0]   qty;
  logic          b_last;

  assign out_ok   = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == lobm_pkg::S_IDLE && out_ok);
  assign in_acc   = in_valid && !in_stall;
  assign sc_m1    = sc_r - CW'(1);
  assign e_idx    = sc_m1[IW-1:0];
  assign age_a    = arr_cnt_r - rd_b_q.arrival;
  assign qty      = (pb_r.remaining < pa_r.remaining) ? pb_r.remaining : pa_r.remaining;
  assign b_last   = (b_r == IW'(BOOK_ENTRIES - 1));

  // Lowest free slot.
  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = BOOK_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        full     = 1'b0;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    arr_cnt_nxt  = arr_cnt_r;
    trd_cnt_nxt  = trd_cnt_r;
    sc_nxt       = sc_r;
    ntr_nxt      = ntr_r;
    b_nxt        = b_r;
    pb_idx_nxt   = pb_idx_r;
    pa_idx_nxt   = pa_idx_r;
    have_bid_nxt = have_bid_r;
    have_ask_nxt = have_ask_r;
    found_nxt    = found_r;
    best_bid_nxt = best_bid_r;
    best_ask_nxt = best_ask_r;
    pb_nxt       = pb_r;
    pa_nxt       = pa_r;
    bd_nxt       = bd_r;
    pb_age_nxt   = pb_age_r;
    pa_age_nxt   = pa_age_r;
    bd_age_nxt   = bd_age_r;
    addr_a       = b_r;
    addr_b       = sc_r[IW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = free_idx;
    mem_wdata    = pb_r;

    out_valid_nxt = out_valid_r && out_stall;
    o_status_nxt  = o_status_r;
    o_tnum_nxt    = o_tnum_r;
    o_buy_nxt     = o_buy_r;
    o_sell_nxt    = o_sell_r;
    o_price_nxt   = o_price_r;
    o_qty_nxt     = o_qty_r;
    o_mkt_nxt     = o_mkt_r;
    o_cur_nxt     = o_cur_r;
    o_done_nxt    = o_done_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      lobm_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_mode) begin
            ntr_nxt      = '0;
            sc_nxt       = '0;
            have_bid_nxt = 1'b0;
            have_ask_nxt = 1'b0;
            state_nxt    = lobm_pkg::S_BEST;
          end else begin
            out_valid_nxt = 1'b1;
            o_tnum_nxt    = '0;
            o_buy_nxt     = '0;
            o_sell_nxt    = '0;
            o_price_nxt   = '0;
            o_qty_nxt     = '0;
            o_mkt_nxt     = '0;
            o_cur_nxt     = '0;
            o_done_nxt    = '0;
            o_last_nxt    = 1'b1;
            if (in_order_quantity == '0) begin
              o_status_nxt = lobm_pkg::ST_ZERO;
            end else if (full) begin
              o_status_nxt = lobm_pkg::ST_FULL;
            end else begin
              o_status_nxt          = lobm_pkg::ST_ADDED;
              mem_we                = 1'b1;
              mem_wdata.side        = in_side;
              mem_wdata.price       = in_limit_price;
              mem_wdata.remaining   = in_order_quantity;
              mem_wdata.order_ident = in_order_ident;
              mem_wdata.instrument  = in_instrument_ident;
              mem_wdata.market      = in_market_code;
              mem_wdata.currency    = in_currency_code;
              mem_wdata.arrival     = arr_cnt_r;
              valid_nxt[free_idx]   = 1'b1;
              arr_cnt_nxt           = arr_cnt_r + 32'd1;
            end
          end
        end
      end
      lobm_pkg::S_BEST: begin
        addr_a = sc_r[IW-1:0];
        if (sc_r != '0 && valid_r[e_idx]) begin
          if (!rd_a_q.side) begin
            if (!have_bid_r || rd_a_q.price > best_bid_r) best_bid_nxt = rd_a_q.price;
            have_bid_nxt = 1'b1;
          end else begin
            if (!have_ask_r || rd_a_q.price < best_ask_r) best_ask_nxt = rd_a_q.price;
            have_ask_nxt = 1'b1;
          end
        end
        if (sc_r == CW'(BOOK_ENTRIES)) state_nxt = lobm_pkg::S_CHECK;
        else sc_nxt = sc_r + CW'(1);
      end
      lobm_pkg::S_CHECK: begin
        if (ntr_r == CW'(BOOK_ENTRIES) || !have_bid_r || !have_ask_r ||
            best_bid_r < best_ask_r) begin
          state_nxt = lobm_pkg::S_DONE;
        end else begin
          b_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = lobm_pkg::S_BRD;
        end
      end
      lobm_pkg::S_BRD: begin
        if (valid_r[b_r]) begin
          state_nxt = lobm_pkg::S_BCHK;
        end else if (b_last) begin
          state_nxt = lobm_pkg::S_TRADE;
        end else begin
          b_nxt = b_r + IW'(1);
        end
      end
      lobm_pkg::S_BCHK: begin
        if (!rd_a_q.side && rd_a_q.price == best_bid_r) begin
          bd_nxt     = rd_a_q;
          bd_age_nxt = arr_cnt_r - rd_a_q.arrival;
          sc_nxt     = '0;
          state_nxt  = lobm_pkg::S_ASCAN;
        end else if (b_last) begin
          state_nxt = lobm_pkg::S_TRADE;
        end else begin
          b_nxt     = b_r + IW'(1);
          state_nxt = lobm_pkg::S_BRD;
        end
      end
      lobm_pkg::S_ASCAN: begin
        // Ask data arrives in the cycle after its address; sc_r runs one ahead.
        if (sc_r != '0 && valid_r[e_idx] && rd_b_q.side &&
            rd_b_q.price == best_ask_r && rd_b_q.instrument == bd_r.instrument &&
            rd_b_q.market == bd_r.market && rd_b_q.currency == bd_r.currency) begin
          if (!found_r || bd_age_r > pb_age_r ||
              (pb_idx_r == b_r && age_a > pa_age_r)) begin
            found_nxt  = 1'b1;
            pb_idx_nxt = b_r;
            pb_nxt     = bd_r;
            pb_age_nxt = bd_age_r;
            pa_idx_nxt = e_idx;
            pa_nxt     = rd_b_q;
            pa_age_nxt = age_a;
          end
        end
        if (sc_r == CW'(BOOK_ENTRIES)) begin
          if (b_last) begin
            state_nxt = lobm_pkg::S_TRADE;
          end else begin
            b_nxt     = b_r + IW'(1);
            state_nxt = lobm_pkg::S_BRD;
          end
        end else begin
          sc_nxt = sc_r + CW'(1);
        end
      end
      lobm_pkg::S_TRADE: begin
        if (!found_r) begin
          state_nxt = lobm_pkg::S_DONE;
        end else if (out_ok) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = lobm_pkg::ST_TRADE;
          o_tnum_nxt    = trd_cnt_r;
          o_buy_nxt     = pb_r.order_ident;
          o_sell_nxt    = pa_r.order_ident;
          o_price_nxt   = pa_r.price;
          o_qty_nxt     = qty;
          o_mkt_nxt     = pb_r.market;
          o_cur_nxt     = pb_r.currency;
          o_done_nxt    = '0;
          o_last_nxt    = 1'b0;
          trd_cnt_nxt   = trd_cnt_r + 32'd1;
          ntr_nxt       = ntr_r + CW'(1);
          mem_we              = 1'b1;
          mem_waddr           = pb_idx_r;
          mem_wdata           = pb_r;
          mem_wdata.remaining = pb_r.remaining - qty;
          pa_nxt.remaining    = pa_r.remaining - qty;
          if (pb_r.remaining == qty) valid_nxt[pb_idx_r] = 1'b0;
          if (pa_r.remaining == qty) valid_nxt[pa_idx_r] = 1'b0;
          state_nxt = lobm_pkg::S_WB2;
        end
      end
      lobm_pkg::S_WB2: begin
        mem_we       = 1'b1;
        mem_waddr    = pa_idx_r;
        mem_wdata    = pa_r;
        sc_nxt       = '0;
        have_bid_nxt = 1'b0;
        have_ask_nxt = 1'b0;
        state_nxt    = lobm_pkg::S_BEST;
      end
      lobm_pkg::S_DONE: begin
        if (out_ok) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = lobm_pkg::ST_DONE;
          o_tnum_nxt    = '0;
          o_buy_nxt     = '0;
          o_sell_nxt    = '0;
          o_price_nxt   = '0;
          o_qty_nxt     = '0;
          o_mkt_nxt     = '0;
          o_cur_nxt     = '0;
          o_done_nxt    = 6'(ntr_r);
          o_last_nxt    = 1'b1;
          state_nxt     = lobm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lobm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lobm_pkg::S_IDLE;
      valid_r     <= '0;
      arr_cnt_r   <= '0;
      trd_cnt_r   <= 32'd1;
      out_valid_r <= 1'b0;
      ntr_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      arr_cnt_r   <= arr_cnt_nxt;
      trd_cnt_r   <= trd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ntr_r       <= ntr_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_r       <= sc_nxt;
    b_r        <= b_nxt;
    pb_idx_r   <= pb_idx_nxt;
    pa_idx_r   <= pa_idx_nxt;
    have_bid_r <= have_bid_nxt;
    have_ask_r <= have_ask_nxt;
    best_bid_r <= best_bid_nxt;
    best_ask_r <= best_ask_nxt;
    pb_r       <= pb_nxt;
    pa_r       <= pa_nxt;
    bd_r       <= bd_nxt;
    pb_age_r   <= pb_age_nxt;
    pa_age_r   <= pa_age_nxt;
    bd_age_r   <= bd_age_nxt;
    o_status_r <= o_status_nxt;
    o_tnum_r   <= o_tnum_nxt;
    o_buy_r    <= o_buy_nxt;
    o_sell_r   <= o_sell_nxt;
    o_price_r  <= o_price_nxt;
    o_qty_r    <= o_qty_nxt;
    o_mkt_r    <= o_mkt_nxt;
    o_cur_r    <= o_cur_nxt;
    o_done_r   <= o_done_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_trade_number   = o_tnum_r;
  assign out_buyer_ident    = o_buy_r;
  assign out_seller_ident   = o_sell_r;
  assign out_trade_price    = o_price_r;
  assign out_trade_quantity = o_qty_r;
  assign out_trade_market   = o_mkt_r;
  assign out_trade_currency = o_cur_r;
  assign out_trades_done    = o_done_r;
  assign out_last           = o_last_r;

  // A trade never moves zero units.
  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_status_r == lobm_pkg::ST_TRADE) |-> (o_qty_r != '0))
    else $error("trade with zero quantity");

  // A match item never runs more rounds than the book has slots.
  a_round_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (ntr_r <= CW'(BOOK_ENTRIES)))
    else $error("round count beyond book size");

  // Only done and add results close an item.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_status_r == lobm_pkg::ST_TRADE) |-> !o_last_r)
    else $error("trade marked as final result");

  // A chosen pair is a bid and an ask.
  a_pair_sides: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lobm_pkg::S_TRADE && found_r) |-> (!pb_r.side && pa_r.side))
    else $error("chosen pair has wrong sides");

endmodule
`default_nettype wire

// ----- tb/lobm_checker.sv -----
module lobm_checker #(
  parameter int BOOK_SLOTS = 32
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_mode,
  input wire logic        in_side,
  input wire logic [31:0] in_limit_price,
  input wire logic [30:0] in_order_quantity,
  input wire logic [31:0] in_order_ident,
  input wire logic [31:0] in_instrument_ident,
  input wire logic [31:0] in_market_code,
  input wire logic [23:0] in_currency_code,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_trade_number,
  input wire logic [31:0] out_buyer_ident,
  input wire logic [31:0] out_seller_ident,
  input wire logic [31:0] out_trade_price,
  input wire logic [30:0] out_trade_quantity,
  input wire logic [31:0] out_trade_market,
  input wire logic [23:0] out_trade_currency,
  input wire logic [5:0]  out_trades_done,
  input wire logic        out_last,
  output int              fail_count,
  output int              pending_count,
  output int              trade_count
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] number;
    logic [31:0] buyer;
    logic [31:0] seller;
    logic [31:0] price;
    logic [30:0] qty;
    logic [31:0] market;
    logic [23:0] currency;
    logic [5:0]  done_cnt;
    logic        last;
  } book_result_t;

  book_result_t expected_results[$];
  logic   live[BOOK_SLOTS];
  lobm_pkg::entry_t slot[BOOK_SLOTS];
  logic [31:0] stamp_now;
  logic [31:0] next_trade;

  initial begin
    fail_count = 0;
    trade_count = 0;
  end

  assign pending_count = expected_results.size();

  function automatic logic [31:0] age(int i);
    return stamp_now - slot[i].arrival;
  endfunction

  // Appends one predicted result at the tail of the queue.
  task automatic queue_result(book_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic book_add();
    book_result_t r;
    int free_slot;
    r = '0;
    r.last = 1'b1;
    free_slot = -1;
    for (int i = BOOK_SLOTS - 1; i >= 0; i--) if (!live[i]) free_slot = i;
    if (in_order_quantity == 0) begin
      r.status = lobm_pkg::ST_ZERO;
    end else if (free_slot < 0) begin
      r.status = lobm_pkg::ST_FULL;
    end else begin
      live[free_slot] = 1'b1;
      slot[free_slot] = '{in_side, in_limit_price, in_order_quantity, in_order_ident,
                          in_instrument_ident, in_market_code, in_currency_code, stamp_now};
      stamp_now++;
      r.status = lobm_pkg::ST_ADDED;
    end
    queue_result(r);
  endtask

  task automatic book_match();
    book_result_t r;
    logic have_bid, have_ask;
    logic [31:0] best_bid, best_ask;
    logic [30:0] q;
    int pb, pa, n;
    n = 0;
    for (int round = 0; round < BOOK_SLOTS; round++) begin
      have_bid = 0; have_ask = 0; best_bid = 0; best_ask = 0; pb = -1; pa = -1;
      for (int i = 0; i < BOOK_SLOTS; i++) begin
        if (!live[i]) continue;
        if (!slot[i].side) begin
          if (!have_bid || slot[i].price > best_bid) best_bid = slot[i].price;
          have_bid = 1;
        end else begin
          if (!have_ask || slot[i].price < best_ask) best_ask = slot[i].price;
          have_ask = 1;
        end
      end
      if (!have_bid || !have_ask || best_bid < best_ask) break;
      // The oldest bid with a compatible ask wins; among its compatible asks the oldest one wins.
      for (int b = 0; b < BOOK_SLOTS; b++) begin
        if (!live[b] || slot[b].side || slot[b].price != best_bid) continue;
        for (int a = 0; a < BOOK_SLOTS; a++) begin
          if (!live[a] || !slot[a].side || slot[a].price != best_ask) continue;
          if (slot[b].instrument != slot[a].instrument || slot[b].market != slot[a].market ||
              slot[b].currency != slot[a].currency) continue;
          if (pb < 0 || age(b) > age(pb) || (b == pb && age(a) > age(pa))) begin
            pb = b;
            pa = a;
          end
        end
      end
      if (pb < 0) break;
      q = slot[pb].remaining < slot[pa].remaining ? slot[pb].remaining : slot[pa].remaining;
      r = '0;
      r.status = lobm_pkg::ST_TRADE;
      r.number = next_trade;
      r.buyer = slot[pb].order_ident;
      r.seller = slot[pa].order_ident;
      r.price = slot[pa].price;
      r.qty = q;
      r.market = slot[pb].market;
      r.currency = slot[pb].currency;
      queue_result(r);
      n++;
      next_trade++;
      slot[pb].remaining -= q;
      slot[pa].remaining -= q;
      if (slot[pb].remaining == 0) live[pb] = 0;
      if (slot[pa].remaining == 0) live[pa] = 0;
    end
    r = '0;
    r.status = lobm_pkg::ST_DONE;
    r.done_cnt = n[5:0];
    r.last = 1'b1;
    queue_result(r);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    book_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < BOOK_SLOTS; i++) live[i] = 0;
      stamp_now = 0;
      next_trade = 1;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_mode) book_match();
        else book_add();
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item, status %0d", out_status);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_status == lobm_pkg::ST_TRADE) trade_count++;
          check_field("status", e.status, out_status);
          check_field("trade_number", e.number, out_trade_number);
          check_field("buyer_ident", e.buyer, out_buyer_ident);
          check_field("seller_ident", e.seller, out_seller_ident);
          check_field("trade_price", e.price, out_trade_price);
          check_field("trade_quantity", e.qty, out_trade_quantity);
          check_field("trade_market", e.market, out_trade_market);
          check_field("trade_currency", e.currency, out_trade_currency);
          check_field("trades_done", e.done_cnt, out_trades_done);
          check_field("last", e.last, out_last);
        end
      end
    end
  end
endmodule

// ----- tb/tb_limit_order_book_matcher.sv -----
module tb_limit_order_book_matcher;

  localparam int BOOK_SLOTS = 32;
  // A full matching pass scans all asks for each bid at the best price, so the
  // limit is generous.
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic        in_side;
  logic [31:0] in_limit_price;
  logic [30:0] in_order_quantity;
  logic [31:0] in_order_ident;
  logic [31:0] in_instrument_ident;
  logic [31:0] in_market_code;
  logic [23:0] in_currency_code;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_trade_number;
  logic [31:0] out_buyer_ident;
  logic [31:0] out_seller_ident;
  logic [31:0] out_trade_price;
  logic [30:0] out_trade_quantity;
  logic [31:0] out_trade_market;
  logic [23:0] out_trade_currency;
  logic [5:0]  out_trades_done;
  logic        out_last;
  int          fail_count;
  int          pending_count;
  int          trade_count;
  int          cycle_count;
  int          items_sent;

  limit_order_book_matcher #(.BOOK_ENTRIES(BOOK_SLOTS)) u_dut (.*);

  lobm_checker #(.BOOK_SLOTS(BOOK_SLOTS)) u_checker (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The watchdog ends a hung run with a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls in runs: some phases never stall, others stall heavily.
  int stall_phase;
  initial begin
    out_stall = 1'b0;
    stall_phase = 0;
  end
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 60) out_stall <= 1'b0;
    else if (stall_phase < 150) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  // One item is held on the input ports until the block accepts it. The
  // sender works in bursts; valid drops only in the random gaps between them.
  int burst_left;
  task automatic send_item(logic mode, logic side, logic [31:0] price, logic [30:0] qty,
                           logic [31:0] ident, logic [31:0] instr, logic [31:0] mkt,
                           logic [23:0] cur);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_side <= side;
    in_limit_price <= price;
    in_order_quantity <= qty;
    in_order_ident <= ident;
    in_instrument_ident <= instr;
    in_market_code <= mkt;
    in_currency_code <= cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Random order: prices and instruments come from a narrow pool so that
  // crosses and compatible pairs are common, with wide values now and then.
  task automatic send_random_order();
    logic [31:0] price;
    logic [30:0] qty;
    logic [31:0] instr;
    logic [31:0] mkt;
    logic [23:0] cur;
    price = ($urandom_range(0, 9) == 0) ? $urandom() : 32'd1000 + $urandom_range(0, 6);
    qty = ($urandom_range(0, 12) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 40));
    instr = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(1, 2));
    mkt = ($urandom_range(0, 15) == 0) ? $urandom() : 32'h584E5953;
    cur = ($urandom_range(0, 15) == 0) ? 24'($urandom()) : 24'h555344;
    send_item(1'b0, 1'($urandom()), price, qty, $urandom(), instr, mkt, cur);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_side = 1'b0;
    in_limit_price = '0;
    in_order_quantity = '0;
    in_order_ident = '0;
    in_instrument_ident = '0;
    in_market_code = '0;
    in_currency_code = '0;
    items_sent = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Matching an empty book, then a zero-quantity add.
    send_item(1'b1, 1'b1, '1, '1, '1, '1, '1, '1);
    send_item(1'b0, 1'b0, 32'd500, 31'd0, 32'd1, 32'd7, 32'h58545345, 24'h455552);
    // Two bids at the same price (time priority) and extreme field values.
    send_item(1'b0, 1'b0, 32'd500, 31'd10, 32'd11, 32'd7, 32'h58545345, 24'h455552);
    send_item(1'b0, 1'b0, 32'd500, 31'd5, 32'd12, 32'd7, 32'h58545345, 24'h455552);
    send_item(1'b0, 1'b0, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              32'hFFFFFFFF, 24'hFFFFFF);
    // An incompatible ask at the best price blocks matching entirely.
    send_item(1'b0, 1'b1, 32'd0, 31'd3, 32'd21, 32'd8, 32'h58545345, 24'h455552);
    send_item(1'b1, 1'b0, '0, '0, '0, '0, '0, '0);
    // A compatible ask with a duplicate identifier that partly fills the big bid.
    send_item(1'b0, 1'b1, 32'd0, 31'h7FFFFFFE, 32'd21, 32'hFFFFFFFF, 32'hFFFFFFFF,
              24'hFFFFFF);
    send_item(1'b0, 1'b1, 32'd400, 31'd12, 32'd22, 32'd7, 32'h58545345, 24'h455552);
    send_item(1'b1, 1'b1, '1, '1, '1, '1, '1, '1);
    // Fill the book to the brim; the last six adds of the run are rejected as full.
    for (int i = 0; i < BOOK_SLOTS + 1; i++)
      send_item(1'b0, 1'(i), 32'd1000 + 32'(i % 3), 31'(i + 1), 32'(100 + i),
                32'd7, 32'h58545345, 24'h455552);
    send_item(1'b1, 1'b0, '0, '0, '0, '0, '0, '0);

    // Random part: runs of orders, each followed by a match, until about 210
    // items have gone in.
    while (items_sent < 210) begin
      repeat ($urandom_range(1, 8)) send_random_order();
      send_item(1'b1, 1'($urandom()), $urandom(), 31'($urandom()), $urandom(),
                $urandom(), $urandom(), 24'($urandom()));
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("Sent %0d items; %0d trades checked, including a full book and",
             items_sent, trade_count);
    $display("blocked, partial and multi-round matches.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
